// ===== hdl/dwec_pkg.sv =====
// Shared types and constants for the dual wheel edge counter with lockout.
// No dependencies; imported by dwec_channel and the top level.
`default_nettype none

package dwec_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned MEAN_W = 31;

    // Lockout window after reset, in timestamp ticks.
    localparam logic [DATA_W-1:0] LOCKOUT_RESET = 32'd14400;

    // Item kind carried on tuser.
    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Per-channel control for one item moving into the state stage.
    typedef struct packed {
        logic step;   // item transfers into the state stage this cycle
        logic clear;  // clear-all item
        logic edge_seen; // this channel flagged an edge
    } t_chan_ctl;

    // Per-channel state as seen after the latest update.
    typedef struct packed {
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] glitches;
        logic [DATA_W-1:0] last_time;
    } t_chan_state;

endpackage : dwec_pkg

`default_nettype wire

// ===== hdl/dwec_channel.sv =====
// One encoder channel: edge count, glitch count and last accepted edge time
// with the lockout compare. Depends on dwec_pkg.
`default_nettype none

module dwec_channel
    import dwec_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_chan_ctl         i_ctl,
    input  wire logic [DATA_W-1:0] i_now,
    input  wire logic [DATA_W-1:0] i_lockout,
    output t_chan_state            o_state
);

    logic [DATA_W-1:0] r_count, n_count;
    logic [DATA_W-1:0] r_glitches, n_glitches;
    logic [DATA_W-1:0] r_last, n_last;
    logic [DATA_W-1:0] gap;
    logic              reject;

    // modular gap, so a wrapped timestamp reads as a long gap
    assign gap    = i_now - r_last;
    assign reject = (gap < i_lockout);

    always_comb begin
        n_count    = r_count;
        n_glitches = r_glitches;
        n_last     = r_last;
        if (i_ctl.step) begin
            if (i_ctl.clear) begin
                n_count    = '0;
                n_glitches = '0;
                n_last     = i_now;
            end else if (i_ctl.edge_seen) begin
                if (reject) begin
                    n_glitches = r_glitches + DATA_W'(1);
                end else begin
                    n_count = r_count + DATA_W'(1);
                    n_last  = i_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_glitches <= '0;
            r_last     <= '0;
        end else begin
            r_count    <= n_count;
            r_glitches <= n_glitches;
            r_last     <= n_last;
        end
    end

    assign o_state.count     = r_count;
    assign o_state.glitches  = r_glitches;
    assign o_state.last_time = r_last;

endmodule : dwec_channel

`default_nettype wire

// ===== hdl/dual_wheel_edge_counter_lockout_core.sv =====
// Dual wheel edge counter with lockout deglitch, top level. Uses dwec_pkg, dwec_channel.
// Each item passes through the input register, the channel state registers and the output register.
// Throughput: one item per cycle unless the output stalls; per-channel compare-and-update is combinational.
// Three-entry pipeline absorbs output stalls; input tready drops only when all stages are full.
// Reset (i_rst_n, synchronous, active low): counts and last times zero, lockout 14400,
// pipeline empty.
`default_nettype none

module dual_wheel_edge_counter_lockout_core
    import dwec_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    // configuration: lockout_cycles
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [DATA_W-1:0] i_cfg_data,

    // input stream
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [39:0]       s_axis_tdata,  // edge_left, edge_right, timestamp[31:0], zero pad
    input  wire logic              s_axis_tuser,  // kind (0 edge/read, 1 clear)

    // result stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [255:0]           m_axis_tdata   // left_count, right_count, mean_count[30:0],
                                                  // count_difference, left_glitches,
                                                  // right_glitches, left_idle_cycles,
                                                  // right_idle_cycles, one zero pad bit
);

    // ------------------------------------------------------------------
    // Configuration: always ready, the lockout register loads on transfer.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] r_lockout;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout <= LOCKOUT_RESET;
        end else if (i_cfg_valid) begin
            r_lockout <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enables. Each stage loads when it is empty or its content
    // moves on in the same cycle.
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic en1, en2, en3;

    assign en3 = !r_out_valid || m_axis_tready;
    assign en2 = !r_s2_valid || en3;
    assign en1 = !r_s1_valid || en2;

    assign s_axis_tready = en1;

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic              r_s1_kind;
    logic              r_s1_left;
    logic              r_s1_right;
    logic [DATA_W-1:0] r_s1_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && s_axis_tvalid) begin
            r_s1_kind  <= s_axis_tuser;
            r_s1_left  <= s_axis_tdata[0];
            r_s1_right <= s_axis_tdata[1];
            r_s1_now   <= s_axis_tdata[33:2];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: channel state. The state registers change only when an item
    // moves into this stage, so they hold this stage's snapshot as long as
    // it waits; only the timestamp needs a register of its own.
    // ------------------------------------------------------------------
    logic        step;
    logic        clear;
    t_chan_ctl   left_ctl, right_ctl;
    t_chan_state left_st, right_st;
    logic [DATA_W-1:0] r_s2_now;

    assign step  = r_s1_valid && en2;
    assign clear = (r_s1_kind == KIND_CLEAR);

    assign left_ctl  = '{step: step, clear: clear, edge_seen: r_s1_left};
    assign right_ctl = '{step: step, clear: clear, edge_seen: r_s1_right};

    dwec_channel u_left (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (left_ctl),
        .i_now     (r_s1_now),
        .i_lockout (r_lockout),
        .o_state   (left_st)
    );

    dwec_channel u_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (right_ctl),
        .i_now     (r_s1_now),
        .i_lockout (r_lockout),
        .o_state   (right_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_s2_now <= r_s1_now;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: derived fields and the output register
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] sum_rnd;
    logic [MEAN_W-1:0] mean;
    logic [DATA_W-1:0] diff;
    logic [DATA_W-1:0] left_idle, right_idle;
    logic [255:0]      n_out_data;
    logic [255:0]      r_out_data;

    assign sum_rnd    = left_st.count + right_st.count + 32'd1;  // wraps at 32 bits
    assign mean       = sum_rnd[DATA_W-1:1];
    assign diff       = left_st.count - right_st.count;
    assign left_idle  = r_s2_now - left_st.last_time;
    assign right_idle = r_s2_now - right_st.last_time;

    assign n_out_data = {1'b0, right_idle, left_idle, right_st.glitches, left_st.glitches,
                         diff, mean, right_st.count, left_st.count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en3) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_s2_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // a clear leaves both channels zeroed with a common last time
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && step && clear) |=>
            (left_st.count == '0 && right_st.count == '0 &&
             left_st.glitches == '0 && right_st.glitches == '0 &&
             left_st.last_time == right_st.last_time))
        else $error("clear did not reset channel state");

    // channel state only moves when an item enters the state stage
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !step) |=>
            ($stable(left_st) && $stable(right_st)))
        else $error("channel state changed without an item");

    // a flagged left edge bumps exactly one of count and glitch count
    a_left_one_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && step && !clear && r_s1_left) |=>
            ((left_st.count != $past(left_st.count)) !=
             (left_st.glitches != $past(left_st.glitches))))
        else $error("left edge updated both or neither counter");

endmodule : dual_wheel_edge_counter_lockout_core

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for dual_wheel_edge_counter_lockout_core: directed and random edge, clear and read
// items, each result checked against an in-bench model. Depends on dwec_pkg and the core RTL.
module tb;
    import dwec_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 10;     // margin after the results have drained
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int          CH_LEFT      = 0;
    localparam int          CH_RIGHT     = 1;

    // Result layout on m_axis_tdata, top bit first.
    typedef struct packed {
        logic              pad;
        logic [DATA_W-1:0] right_idle;
        logic [DATA_W-1:0] left_idle;
        logic [DATA_W-1:0] right_glitches;
        logic [DATA_W-1:0] left_glitches;
        logic [DATA_W-1:0] difference;
        logic [MEAN_W-1:0] mean;
        logic [DATA_W-1:0] right_count;
        logic [DATA_W-1:0] left_count;
    } t_snapshot;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [DATA_W-1:0] cfg_data  = '0;
    logic              s_valid   = 1'b0;
    logic [39:0]       s_data    = '0;
    logic              s_kind    = KIND_EDGE;
    logic              m_ready   = 1'b0;
    logic              rx_hold   = 1'b0;
    wire               cfg_ready;
    wire               s_ready;
    wire               m_valid;
    wire  [255:0]      m_data;

    // Counter model, updated at each input transfer.
    logic [DATA_W-1:0] lockout_model = LOCKOUT_RESET;
    logic [DATA_W-1:0] edge_cnt[2]   = '{default: '0};
    logic [DATA_W-1:0] glitch_cnt[2] = '{default: '0};
    logic [DATA_W-1:0] last_time[2]  = '{default: '0};

    t_snapshot   pending_snapshots[$];
    int unsigned failures    = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;

    dual_wheel_edge_counter_lockout_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_kind),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_snapshots.size());
            $display("tb failed");
            $finish;
        end
    end

    // Output side: random stalls, or a forced hold-off during the backpressure test.
    always @(posedge i_clk) begin
        if (rx_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Apply one item to the model and return the snapshot it should produce.
    function automatic t_snapshot update_counters(input logic kind, input logic edge_l,
                                                  input logic edge_r, input logic [DATA_W-1:0] ts);
        t_snapshot         snap;
        logic              flag[2];
        logic [DATA_W-1:0] gap;
        logic [DATA_W-1:0] sum;
        flag[CH_LEFT]  = edge_l;
        flag[CH_RIGHT] = edge_r;
        for (int ch = 0; ch < 2; ch++) begin
            if (kind == KIND_CLEAR) begin
                edge_cnt[ch]   = '0;
                glitch_cnt[ch] = '0;
                last_time[ch]  = ts;
            end else if (flag[ch]) begin
                gap = ts - last_time[ch];
                if (gap < lockout_model) begin
                    glitch_cnt[ch] = glitch_cnt[ch] + 1;
                end else begin
                    last_time[ch] = ts;
                    edge_cnt[ch]  = edge_cnt[ch] + 1;
                end
            end
        end
        sum                 = edge_cnt[CH_LEFT] + edge_cnt[CH_RIGHT] + 32'd1;
        snap.pad            = 1'b0;
        snap.left_count     = edge_cnt[CH_LEFT];
        snap.right_count    = edge_cnt[CH_RIGHT];
        snap.mean           = sum[DATA_W-1:1];
        snap.difference     = edge_cnt[CH_LEFT] - edge_cnt[CH_RIGHT];
        snap.left_glitches  = glitch_cnt[CH_LEFT];
        snap.right_glitches = glitch_cnt[CH_RIGHT];
        snap.left_idle      = ts - last_time[CH_LEFT];
        snap.right_idle     = ts - last_time[CH_RIGHT];
        return snap;
    endfunction

    // Timestamps clustered around the lockout boundary of either channel, plus some noise.
    function automatic logic [DATA_W-1:0] pick_timestamp();
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] span;
        base = last_time[$urandom_range(1)];
        span = (lockout_model == 0) ? 32'd16 : lockout_model;
        case ($urandom_range(6))
            0:       return base + span - 32'd1;
            1:       return base + span;
            2:       return base + span + 32'd1;
            3:       return base + 32'($urandom_range(3));
            4:       return $urandom();
            5:       return base + span + 32'($urandom_range(span));
            default: return base + 32'($urandom_range(span));
        endcase
    endfunction

    task automatic send_item(input logic kind, input logic edge_l, input logic edge_r,
                             input logic [DATA_W-1:0] ts);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_data  <= {6'b0, ts, edge_r, edge_l};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        pending_snapshots.push_back(update_counters(kind, edge_l, edge_r, ts));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_snapshots.size() != 0) @(posedge i_clk);
    endtask

    // Only written with the pipeline empty; every item yields a result, so empty means idle.
    task automatic write_lockout(input logic [DATA_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid     <= 1'b0;
        lockout_model = value;
    endtask

    task automatic send_random_items(input int unsigned count);
        int unsigned pick;
        logic [1:0]  flags;
        for (int unsigned k = 0; k < count; k++) begin
            pick  = $urandom_range(99);
            flags = 2'($urandom_range(1, 3));
            if (pick < 5) begin
                send_item(KIND_CLEAR, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          pick_timestamp());
            end else if (pick < 12) begin
                send_item(KIND_EDGE, 1'b0, 1'b0, pick_timestamp());
            end else begin
                send_item(KIND_EDGE, flags[0], flags[1], pick_timestamp());
            end
        end
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] seen);
        if (want !== seen) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_snapshot want;
        t_snapshot seen;
        if (i_rst_n && m_valid && m_ready) begin
            seen = m_data;
            if (pending_snapshots.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, m_data);
                failures++;
            end else begin
                want = pending_snapshots.pop_front();
                check_field("left_count", want.left_count, seen.left_count);
                check_field("right_count", want.right_count, seen.right_count);
                check_field("mean_count", {1'b0, want.mean}, {1'b0, seen.mean});
                check_field("count_difference", want.difference, seen.difference);
                check_field("left_glitches", want.left_glitches, seen.left_glitches);
                check_field("right_glitches", want.right_glitches, seen.right_glitches);
                check_field("left_idle_cycles", want.left_idle, seen.left_idle);
                check_field("right_idle_cycles", want.right_idle, seen.right_idle);
            end
        end
    end

    // Reset lockout: window edges, both channels, clears with flags, timestamp wrap.
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_item(KIND_EDGE, 1'b0, 1'b0, 32'd0);
        send_item(KIND_EDGE, 1'b1, 1'b0, 32'd100);
        send_item(KIND_EDGE, 1'b0, 1'b1, 32'd14399);
        send_item(KIND_EDGE, 1'b1, 1'b1, 32'd14400);
        send_item(KIND_EDGE, 1'b1, 1'b1, 32'd28799);
        send_item(KIND_EDGE, 1'b1, 1'b0, 32'd28800);
        send_item(KIND_EDGE, 1'b0, 1'b1, 32'd28801);
        send_item(KIND_CLEAR, 1'b1, 1'b1, 32'hFFFF_FFF0);
        send_item(KIND_EDGE, 1'b1, 1'b0, 32'hFFFF_FF00);  // wraps to a huge gap
        send_item(KIND_EDGE, 1'b0, 1'b1, 32'h0000_1000);  // gap across zero, inside window
        send_item(KIND_EDGE, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_item(KIND_CLEAR, 1'b0, 1'b0, 32'd0);
    endtask

    // Zero lockout accepts even a zero gap; all-ones lockout needs a gap of all ones.
    task automatic test_lockout_extremes();
        write_lockout(32'd0);
        send_item(KIND_EDGE, 1'b1, 1'b1, 32'd5);
        send_item(KIND_EDGE, 1'b1, 1'b1, 32'd5);
        send_item(KIND_EDGE, 1'b1, 1'b0, 32'd4);
        write_lockout(32'hFFFF_FFFF);
        send_item(KIND_EDGE, 1'b1, 1'b1, 32'd3);
        send_item(KIND_EDGE, 1'b1, 1'b1, 32'd3);
        send_item(KIND_EDGE, 1'b0, 1'b0, 32'd0);
    endtask

    task automatic test_random_phases();
        write_lockout(32'd1);
        send_idle_pct = 0;
        stall_pct     = 0;
        send_random_items(260);
        write_lockout(LOCKOUT_RESET);
        send_idle_pct = 86;
        stall_pct     = 0;
        send_random_items(260);
        write_lockout(32'h8000_0000);
        send_idle_pct = 0;
        stall_pct     = 86;
        send_random_items(260);
        write_lockout(32'd300);
        send_idle_pct = 38;
        stall_pct     = 38;
        send_random_items(260);
        write_lockout(32'hFFFF_FFFF);
        send_idle_pct = 0;
        stall_pct     = 0;
        send_random_items(60);
    endtask

    // Long receiver hold-off while items keep coming, so the pipeline fills and s_axis stalls.
    task automatic test_output_backpressure();
        write_lockout(32'd50);
        send_idle_pct = 0;
        stall_pct     = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        send_random_items(60);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_lockout_extremes();
        test_random_phases();
        test_output_backpressure();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_snapshots.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_snapshots.size());
            failures++;
        end
        if (failures == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
